@@ hw/rtl/utf8_to_utf16_swapped_macros.svh @@
// Assertion macros for the UTF-8 to UTF-16 decoder RTL.
`ifndef UTF8_TO_UTF16_SWAPPED_MACROS_SVH
`define UTF8_TO_UTF16_SWAPPED_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define U8U16_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define U8U16_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hw/rtl/u8u16_pkg.sv @@
// Types and constants for the UTF-8 to byte-swapped UTF-16 decoder.
package u8u16_pkg;

  localparam logic [6:0]  UnitCap  = 7'd64;
  localparam logic [6:0]  CfgReset = 7'd50;
  localparam logic [15:0] QMark    = 16'h003F;

  // One input byte with its end-of-string flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in;
  } item_t;

  // Status from the decode stage back to the top level.
  typedef struct packed {
    logic [6:0] units;
    logic       step;
    logic       step_last;
  } status_t;

endpackage

@@ hw/rtl/u8u16_in_if.sv @@
// Stream interface carrying UTF-8 bytes.
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in;

  modport source (output valid, output in_byte, output last_in, input ready);
  modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

@@ hw/rtl/u8u16_out_if.sv @@
// Stream interface carrying byte-swapped UTF-16 code units.
interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [5:0]  unit_index;

  modport source (output valid, output code_unit, output unit_index, input ready);
  modport sink   (input valid, input code_unit, input unit_index, output ready);
endinterface

@@ hw/rtl/u8u16_core.sv @@
// Decode stage: string state, unit assembly and the result register.
module u8u16_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  u8u16_pkg::item_t     item_i,
  input  logic [6:0]           limit_i,
  output logic                 item_take_o,
  output u8u16_pkg::status_t   status_o,
  u8u16_out_if.source          out_o
);

  logic [15:0] partial_q, partial_d;
  logic [1:0]  rem_q, rem_d;
  logic        skip_q, skip_d;
  logic [6:0]  units_q, units_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_unit_q, out_unit_d;
  logic [5:0]  out_idx_q, out_idx_d;

  logic        take;
  logic        have;
  logic        emit;
  logic [15:0] unit;
  logic [7:0]  b;

  assign b    = item_i.in_byte;
  assign take = item_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    partial_d = partial_q;
    rem_d     = rem_q;
    skip_d    = skip_q;
    units_d   = units_q;
    have      = 1'b0;
    unit      = 16'd0;
    if (rem_q != 2'd0) begin
      rem_d = rem_q - 2'd1;
      if (!skip_q) begin
        partial_d = {partial_q[9:0], b[5:0]};
        if (rem_d == 2'd0) begin
          have = 1'b1;
          unit = partial_d;
        end
      end else if (rem_d == 2'd0) begin
        skip_d = 1'b0;
      end
    end else if (b[7:6] == 2'b11) begin
      if (b[5]) begin
        if (b[4]) begin
          have   = 1'b1;
          unit   = u8u16_pkg::QMark;
          skip_d = 1'b1;
          rem_d  = 2'd3;
        end else begin
          partial_d = {12'd0, b[3:0]};
          rem_d     = 2'd2;
        end
      end else begin
        partial_d = {11'd0, b[4:0]};
        rem_d     = 2'd1;
      end
    end else begin
      have = 1'b1;
      unit = {9'd0, b[6:0]};
    end

    emit = have && (units_q < limit_i);
    if (emit) begin
      units_d = units_q + 7'd1;
    end
    // End of string: drop any partial sequence or pending skip and restart the unit count.
    if (item_i.last_in) begin
      partial_d = 16'd0;
      rem_d     = 2'd0;
      skip_d    = 1'b0;
      units_d   = 7'd0;
    end
  end

  always_comb begin
    out_unit_d  = out_unit_q;
    out_idx_d   = out_idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (take) begin
      out_valid_d = emit;
      if (emit) begin
        out_unit_d = {unit[7:0], unit[15:8]};
        out_idx_d  = units_q[5:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= 16'd0;
      rem_q       <= 2'd0;
      skip_q      <= 1'b0;
      units_q     <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        partial_q <= partial_d;
        rem_q     <= rem_d;
        skip_q    <= skip_d;
        units_q   <= units_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_unit_q <= out_unit_d;
    out_idx_q  <= out_idx_d;
  end

  assign item_take_o          = take;
  assign status_o.units       = units_q;
  assign status_o.step        = take;
  assign status_o.step_last   = item_i.last_in;
  assign out_o.valid          = out_valid_q;
  assign out_o.code_unit      = out_unit_q;
  assign out_o.unit_index     = out_idx_q;

endmodule

@@ hw/rtl/utf8_to_utf16_swapped.sv @@
// Top level of the streaming UTF-8 to byte-swapped UTF-16 decoder.
// An accepted byte passes through the input register, then the result register.
// Throughput: one byte per cycle while units are taken; the input and result registers
// let a new byte enter while a finished unit waits to be taken.
// Reset: asynchronous, active low; clears string state and both stages and
// loads the unit limit with 50.
`include "utf8_to_utf16_swapped_macros.svh"

module utf8_to_utf16_swapped (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [6:0]   cfg_wdata_i,
  u8u16_in_if.sink     in_i,
  u8u16_out_if.source  out_o
);

  // Unit limit register, saturated to the cap before use.
  logic [6:0] max_units_q;
  logic [6:0] limit;

  // Input register ahead of the decode stage.
  logic              s1_valid_q;
  u8u16_pkg::item_t  s1_item_q;
  logic              s1_take;
  u8u16_pkg::status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= u8u16_pkg::CfgReset;
    end else if (cfg_we_i) begin
      max_units_q <= cfg_wdata_i;
    end
  end

  assign limit = (max_units_q > u8u16_pkg::UnitCap) ? u8u16_pkg::UnitCap : max_units_q;

  // Accept a byte whenever the input register is empty or drains this cycle.
  assign in_i.ready = !s1_valid_q || s1_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Hold the payload until the decode stage takes it.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_item_q.in_byte <= in_i.in_byte;
      s1_item_q.last_in <= in_i.last_in;
    end
  end

  u8u16_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s1_valid_q),
    .item_i       (s1_item_q),
    .limit_i      (limit),
    .item_take_o  (s1_take),
    .status_o     (status),
    .out_o        (out_o)
  );

  // Unit counter never passes the cap.
  `U8U16_ASSERT(a_units_cap, status.units <= u8u16_pkg::UnitCap, "unit count above cap")
  // Final byte of a string restarts the count.
  `U8U16_ASSERT(a_last_clears, (status.step && status.step_last) |=> (status.units == 7'd0),
                "count not cleared after final byte")
  // Never take a byte while a full input register is blocked.
  `U8U16_ASSERT_NEVER(a_no_overrun, s1_valid_q && !s1_take && in_i.ready,
                      "input register overrun")

endmodule

@@ dv/utf8_to_utf16_swapped_tb.sv @@
// Self-checking testbench for the UTF-8 to byte-swapped UTF-16 decoder.
`timescale 1ns / 1ps

module utf8_to_utf16_swapped_tb;

  // Cycles to let pass once the expected-unit queue drains. Covers the
  // input and result registers plus margin, since a byte may still be in
  // flight that produces no unit at all.
  localparam int SettleCycles = 8;
  // Cycles without any transfer on either channel before the run is called hung.
  localparam int StallLimit = 5000;
  localparam int ResetCycles = 12;

  // One expected code unit as the block should offer it.
  typedef struct packed {
    logic [15:0] code_unit;
    logic [5:0]  unit_index;
  } unit_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [6:0] cfg_wdata_i;

  u8u16_in_if  byte_if ();
  u8u16_out_if unit_if ();

  utf8_to_utf16_swapped u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (byte_if),
    .out_o       (unit_if)
  );

  always #4 clk_i = ~clk_i;

  // Decoder shadow: its own copy of the string state and of the unit limit.
  logic [6:0]  unit_limit = u8u16_pkg::CfgReset;
  logic [15:0] acc_bits = '0;
  logic [1:0]  bytes_left = '0;
  logic        in_skip = 1'b0;
  logic [6:0]  units_out = '0;

  unit_exp_t pending_units[$];

  int fail_count = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Decode one accepted byte and queue the unit it yields, if any.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic        have;
    logic [15:0] unit;
    logic [6:0]  lim;
    unit_exp_t   e;
    have = 1'b0;
    unit = '0;
    // Saturate the limit at the unit cap; zero lets nothing out.
    lim = (unit_limit > u8u16_pkg::UnitCap) ? u8u16_pkg::UnitCap : unit_limit;
    if (bytes_left != 2'd0) begin
      // Inside a sequence: gather continuation bits or burn a skipped byte.
      bytes_left = bytes_left - 2'd1;
      if (!in_skip) begin
        acc_bits = {acc_bits[9:0], b[5:0]};
        if (bytes_left == 2'd0) begin
          unit = acc_bits;
          have = 1'b1;
        end
      end else if (bytes_left == 2'd0) begin
        in_skip = 1'b0;
      end
    end else if (b[7:6] == 2'b11) begin
      if (b[5]) begin
        if (b[4]) begin
          // Four-byte lead: emit the replacement now, skip the next three.
          unit = u8u16_pkg::QMark;
          have = 1'b1;
          in_skip = 1'b1;
          bytes_left = 2'd3;
        end else begin
          acc_bits = {12'd0, b[3:0]};
          bytes_left = 2'd2;
        end
      end else begin
        acc_bits = {11'd0, b[4:0]};
        bytes_left = 2'd1;
      end
    end else begin
      // Plain byte or stray continuation: low seven bits pass straight through.
      unit = {9'd0, b[6:0]};
      have = 1'b1;
    end
    if (have && units_out < lim) begin
      e.code_unit  = {unit[7:0], unit[15:8]};
      e.unit_index = units_out[5:0];
      pending_units.push_back(e);
      units_out = units_out + 7'd1;
    end
    // End of string: drop any partial sequence, cancel a pending skip and restart the unit count.
    if (last) begin
      acc_bits = '0;
      bytes_left = '0;
      in_skip = 1'b0;
      units_out = '0;
    end
  endtask

  // Sample both channels and the config port at every rising edge.
  always @(posedge clk_i) begin : monitor
    unit_exp_t want;
    if (rst_ni) begin
      if (cfg_we_i) unit_limit = cfg_wdata_i;
      if (byte_if.valid && byte_if.ready) decode_byte(byte_if.in_byte, byte_if.last_in);
      if (unit_if.valid && unit_if.ready) begin
        if (pending_units.size() == 0) begin
          $display("%0t: unexpected unit: expected none, actual code_unit %h unit_index %0d",
                   $time, unit_if.code_unit, unit_if.unit_index);
          fail_count++;
        end else begin
          want = pending_units.pop_front();
          if (want.code_unit !== unit_if.code_unit) begin
            $display("%0t: code_unit mismatch: expected %h, actual %h",
                     $time, want.code_unit, unit_if.code_unit);
            fail_count++;
          end
          if (want.unit_index !== unit_if.unit_index) begin
            $display("%0t: unit_index mismatch: expected %0d, actual %0d",
                     $time, want.unit_index, unit_if.unit_index);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_if.valid && byte_if.ready) || (unit_if.valid && unit_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver back-pressure: drop ready at random per the current idle rate.
  always @(negedge clk_i) begin
    unit_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Offer one byte, idling at random first; return once it is transferred.
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid   <= 1'b1;
    byte_if.in_byte <= b;
    byte_if.last_in <= last;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
  endtask

  // Drop valid, wait for every expected unit, then let the pipeline drain.
  task automatic settle();
    @(negedge clk_i);
    byte_if.valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the unit limit; call only after settle().
  task automatic write_limit(input logic [6:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Continuation byte: mostly well formed, sometimes any byte (not checked).
  function automatic logic [7:0] rand_cont();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // Send a string of n_chars characters; the last byte carries last_in.
  // Occasionally cut the final character short to exercise the drop.
  task automatic send_string(input int n_chars);
    logic [7:0] seq[4];
    int len;
    int pick;
    for (int c = 0; c < n_chars; c++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        seq[0] = {1'b0, 7'($urandom_range(0, 127))};
        len = 1;
      end else if (pick < 60) begin
        seq[0] = {3'b110, 5'($urandom_range(0, 31))};
        seq[1] = rand_cont();
        len = 2;
      end else if (pick < 80) begin
        seq[0] = {4'b1110, 4'($urandom_range(0, 15))};
        seq[1] = rand_cont();
        seq[2] = rand_cont();
        len = 3;
      end else if (pick < 88) begin
        seq[0] = {5'b11110, 3'($urandom_range(0, 7))};
        seq[1] = rand_cont();
        seq[2] = rand_cont();
        seq[3] = rand_cont();
        len = 4;
      end else begin
        // Noise: any byte, which may start or break a sequence.
        seq[0] = 8'($urandom_range(0, 255));
        len = 1;
      end
      if (c == n_chars - 1 && len > 1 && $urandom_range(0, 6) == 0)
        len = $urandom_range(1, len - 1);
      for (int j = 0; j < len; j++)
        send_byte(seq[j], (c == n_chars - 1) && (j == len - 1));
    end
  endtask

  // Field extremes and each decode path under the reset limit.
  task automatic test_directed();
    send_byte(8'h00, 1'b0);  // lowest ASCII
    send_byte(8'h7F, 1'b0);  // highest ASCII
    send_byte(8'h80, 1'b0);  // stray continuation, lowest
    send_byte(8'hBF, 1'b0);  // stray continuation, highest
    send_byte(8'hC2, 1'b0);  // two-byte U+00A9
    send_byte(8'hA9, 1'b0);
    send_byte(8'hDF, 1'b0);  // largest two-byte value
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC3, 1'b0);  // unchecked continuation: ASCII byte used as one
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);  // three-byte euro sign
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hEF, 1'b0);  // largest three-byte value
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0);  // four-byte lead: replacement, skip three
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);  // 11111xxx also takes the four-byte path; end string
    send_byte(8'hE2, 1'b0);  // three-byte sequence cut by end of string
    send_byte(8'h82, 1'b1);
    send_byte(8'hF0, 1'b0);  // skip cancelled by end of string
    send_byte(8'h9F, 1'b1);
    send_byte(8'h41, 1'b1);  // decodes normally on a fresh string
  endtask

  // Unit limit at zero, one, the cap and above the cap.
  task automatic test_unit_limit();
    logic [6:0] limits[4];
    limits = '{7'd0, 7'd1, u8u16_pkg::UnitCap, 7'd127};
    foreach (limits[i]) begin
      settle();
      write_limit(limits[i]);
      send_string((limits[i] <= 7'd1) ? 5 : 72);
    end
  endtask

  // Random strings under a few random limits at the given idle rates.
  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_bytes);
    int quota;
    int pick;
    logic [6:0] lim;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int seg = 0; seg < 3; seg++) begin
      settle();
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          lim = 7'd1;
        end
        1: begin
          lim = u8u16_pkg::UnitCap;
        end
        2: begin
          lim = 7'($urandom_range(65, 127));
        end
        3: begin
          lim = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'd2;
        end
        default: begin
          lim = 7'($urandom_range(2, 63));
        end
      endcase
      write_limit(lim);
      quota = bytes_sent + n_bytes / 3;
      while (bytes_sent < quota) begin
        if ($urandom_range(0, 9) == 0) send_string($urandom_range(60, 75));
        else send_string($urandom_range(1, 12));
      end
    end
  endtask

  initial begin
    // Hold every input at a known value through reset.
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    byte_if.valid   = 1'b0;
    byte_if.in_byte = '0;
    byte_if.last_in = 1'b0;
    unit_if.ready   = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    tx_idle_pct = 15;
    rx_idle_pct = 72;
    test_directed();
    test_unit_limit();
    test_random_traffic(15, 72, 120);
    test_random_traffic(72, 15, 120);
    test_random_traffic(0, 0, 120);

    settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ utf8_to_utf16_swapped.f @@
+incdir+hw/rtl
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_in_if.sv
hw/rtl/u8u16_out_if.sv
hw/rtl/u8u16_core.sv
hw/rtl/utf8_to_utf16_swapped.sv
dv/utf8_to_utf16_swapped_tb.sv
